// ===== sv/assert_macros.svh =====
// assertion helpers included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/ftl_pkg.sv =====
`timescale 1ns / 1ps

package ftl_pkg;

	localparam int MAX_TOKEN_LEN_DEF = 49;
	localparam int POS_W = 16;
	localparam int LEN_W = 6;

	typedef enum logic [3:0] {
		KIND_EQUAL         = 4'd0,
		KIND_CELL          = 4'd1,
		KIND_NUMBER        = 4'd2,
		KIND_PLUS          = 4'd3,
		KIND_MINUS         = 4'd4,
		KIND_MULTIPLY      = 4'd5,
		KIND_DIVIDE        = 4'd6,
		KIND_FUNCTION      = 4'd7,
		KIND_LPAREN        = 4'd8,
		KIND_RPAREN        = 4'd9,
		KIND_COLON         = 4'd10,
		KIND_LESS          = 4'd11,
		KIND_GREATER       = 4'd12,
		KIND_LESS_EQUAL    = 4'd13,
		KIND_GREATER_EQUAL = 4'd14,
		KIND_NOT_EQUAL     = 4'd15
	} tok_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE          = 2'd0,
		ERR_INVALID_IDENT = 2'd1,
		ERR_UNEXPECTED    = 2'd2,
		ERR_TOO_LONG      = 2'd3
	} err_code_t;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_LETTERS = 3'd1,
		MODE_CELLDIG = 3'd2,
		MODE_NUMINT  = 3'd3,
		MODE_NUMFRAC = 3'd4,
		MODE_LT      = 3'd5,
		MODE_GT      = 3'd6
	} lex_mode_t;

	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;

	typedef struct packed {
		tok_kind_t         kind;
		logic [POS_W-1:0]  start;
		logic [LEN_W-1:0]  len;
		err_code_t         err;
		logic              last;
	} res_t;

	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

// ===== sv/ftl_out_fifo.sv =====
`timescale 1ns / 1ps

module ftl_out_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  ftl_pkg::push_t push,
	input  logic          pop,
	output logic          room,
	output logic          head_valid,
	output ftl_pkg::res_t head
);

	ftl_pkg::res_t mem_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;
	logic       do_pop;

	assign head_valid = (count_q != 3'd0);
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;
	// two free slots needed, an item may give two results
	assign room       = (count_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_ptr_q + 2'd1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.cnt;
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + {1'b0, push.cnt} - {2'b00, do_pop};
		end
	end

endmodule

// ===== sv/ftl_lex_core.sv =====
`timescale 1ns / 1ps

module ftl_lex_core #(
	parameter int MAX_TOKEN_LEN = ftl_pkg::MAX_TOKEN_LEN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     in_byte,
	input  logic           in_end,
	input  logic           room,
	output ftl_pkg::push_t push
);

	localparam logic [ftl_pkg::LEN_W-1:0] MAX_LEN = ftl_pkg::LEN_W'(MAX_TOKEN_LEN);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       step;

	// lexer state
	ftl_pkg::lex_mode_t          mode_q, mode_d;
	logic [ftl_pkg::POS_W-1:0]   bp_q, bp_d;
	logic [ftl_pkg::POS_W-1:0]   ps_q, ps_d;
	logic [ftl_pkg::LEN_W-1:0]   pl_q, pl_d;
	logic                        err_q, err_d;

	// byte classes
	logic c_alpha, c_digit, c_space;

	// idle handling of the byte
	logic               i_emit, i_fail, i_begin;
	ftl_pkg::lex_mode_t i_mode;
	ftl_pkg::res_t      i_res;

	// decode of current mode against byte
	logic                      ext, ovf, fl_v, fl_fail, run_idle, done;
	ftl_pkg::lex_mode_t        ext_mode;
	ftl_pkg::tok_kind_t        fl_kind;
	logic [ftl_pkg::LEN_W-1:0] fl_len;
	ftl_pkg::err_code_t        fl_err;

	// results
	logic [1:0]    n;
	ftl_pkg::res_t r0, r1;

	assign step     = valid_s1 && room;
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			end_s1  <= in_end;
		end
	end

	assign c_alpha = (byte_s1 inside {[8'h41:8'h5A], [8'h61:8'h7A]});
	assign c_digit = (byte_s1 inside {[8'h30:8'h39]});
	assign c_space = (byte_s1 == 8'h20) || (byte_s1 inside {[8'h09:8'h0D]});

	always_comb begin
		i_emit  = 1'b0;
		i_fail  = 1'b0;
		i_begin = 1'b0;
		i_mode  = ftl_pkg::MODE_IDLE;
		i_res   = '{kind: ftl_pkg::KIND_EQUAL, start: bp_q, len: ftl_pkg::LEN_W'(1),
			err: ftl_pkg::ERR_NONE, last: 1'b0};
		if (c_space) begin
			i_mode = ftl_pkg::MODE_IDLE;
		end else if (c_alpha) begin
			i_begin = 1'b1;
			i_mode  = ftl_pkg::MODE_LETTERS;
		end else if (c_digit) begin
			i_begin = 1'b1;
			i_mode  = ftl_pkg::MODE_NUMINT;
		end else if (byte_s1 == ftl_pkg::CH_LT) begin
			i_begin = 1'b1;
			i_mode  = ftl_pkg::MODE_LT;
		end else if (byte_s1 == ftl_pkg::CH_GT) begin
			i_begin = 1'b1;
			i_mode  = ftl_pkg::MODE_GT;
		end else begin
			i_emit = 1'b1;
			unique case (byte_s1)
				ftl_pkg::CH_EQUAL:  i_res.kind = ftl_pkg::KIND_EQUAL;
				ftl_pkg::CH_PLUS:   i_res.kind = ftl_pkg::KIND_PLUS;
				ftl_pkg::CH_MINUS:  i_res.kind = ftl_pkg::KIND_MINUS;
				ftl_pkg::CH_STAR:   i_res.kind = ftl_pkg::KIND_MULTIPLY;
				ftl_pkg::CH_SLASH:  i_res.kind = ftl_pkg::KIND_DIVIDE;
				ftl_pkg::CH_LPAREN: i_res.kind = ftl_pkg::KIND_LPAREN;
				ftl_pkg::CH_RPAREN: i_res.kind = ftl_pkg::KIND_RPAREN;
				ftl_pkg::CH_COLON:  i_res.kind = ftl_pkg::KIND_COLON;
				default: begin
					i_res.err = ftl_pkg::ERR_UNEXPECTED;
					i_fail    = 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		ext      = 1'b0;
		ext_mode = mode_q;
		fl_v     = 1'b0;
		fl_kind  = ftl_pkg::KIND_EQUAL;
		fl_len   = pl_q;
		fl_err   = ftl_pkg::ERR_NONE;
		fl_fail  = 1'b0;
		run_idle = 1'b0;
		done     = 1'b0;
		if (end_s1) begin
			if (!err_q) begin
				unique case (mode_q) inside
					ftl_pkg::MODE_LETTERS: begin
						fl_v   = 1'b1;
						fl_err = ftl_pkg::ERR_INVALID_IDENT;
					end
					ftl_pkg::MODE_CELLDIG: begin
						fl_v    = 1'b1;
						fl_kind = ftl_pkg::KIND_CELL;
					end
					ftl_pkg::MODE_NUMINT, ftl_pkg::MODE_NUMFRAC: begin
						fl_v    = 1'b1;
						fl_kind = ftl_pkg::KIND_NUMBER;
					end
					ftl_pkg::MODE_LT: begin
						fl_v    = 1'b1;
						fl_kind = ftl_pkg::KIND_LESS;
						fl_len  = ftl_pkg::LEN_W'(1);
					end
					ftl_pkg::MODE_GT: begin
						fl_v    = 1'b1;
						fl_kind = ftl_pkg::KIND_GREATER;
						fl_len  = ftl_pkg::LEN_W'(1);
					end
					default: fl_v = 1'b0;
				endcase
			end
		end else if (!err_q) begin
			unique case (mode_q) inside
				ftl_pkg::MODE_LETTERS: begin
					if (c_alpha) begin
						ext = 1'b1;
					end else if (c_digit) begin
						ext      = 1'b1;
						ext_mode = ftl_pkg::MODE_CELLDIG;
					end else if (byte_s1 == ftl_pkg::CH_LPAREN) begin
						fl_v     = 1'b1;
						fl_kind  = ftl_pkg::KIND_FUNCTION;
						run_idle = 1'b1;
					end else begin
						fl_v    = 1'b1;
						fl_err  = ftl_pkg::ERR_INVALID_IDENT;
						fl_fail = 1'b1;
					end
				end
				ftl_pkg::MODE_CELLDIG: begin
					if (c_digit) begin
						ext = 1'b1;
					end else begin
						fl_v     = 1'b1;
						fl_kind  = ftl_pkg::KIND_CELL;
						run_idle = 1'b1;
					end
				end
				ftl_pkg::MODE_NUMINT, ftl_pkg::MODE_NUMFRAC: begin
					if (c_digit) begin
						ext = 1'b1;
					end else if (byte_s1 == ftl_pkg::CH_DOT &&
						mode_q == ftl_pkg::MODE_NUMINT) begin
						ext      = 1'b1;
						ext_mode = ftl_pkg::MODE_NUMFRAC;
					end else begin
						fl_v     = 1'b1;
						fl_kind  = ftl_pkg::KIND_NUMBER;
						run_idle = 1'b1;
					end
				end
				ftl_pkg::MODE_LT: begin
					fl_v = 1'b1;
					if (byte_s1 == ftl_pkg::CH_EQUAL) begin
						fl_kind = ftl_pkg::KIND_LESS_EQUAL;
						fl_len  = ftl_pkg::LEN_W'(2);
						done    = 1'b1;
					end else if (byte_s1 == ftl_pkg::CH_GT) begin
						fl_kind = ftl_pkg::KIND_NOT_EQUAL;
						fl_len  = ftl_pkg::LEN_W'(2);
						done    = 1'b1;
					end else begin
						fl_kind  = ftl_pkg::KIND_LESS;
						fl_len   = ftl_pkg::LEN_W'(1);
						run_idle = 1'b1;
					end
				end
				ftl_pkg::MODE_GT: begin
					fl_v = 1'b1;
					if (byte_s1 == ftl_pkg::CH_EQUAL) begin
						fl_kind = ftl_pkg::KIND_GREATER_EQUAL;
						fl_len  = ftl_pkg::LEN_W'(2);
						done    = 1'b1;
					end else begin
						fl_kind  = ftl_pkg::KIND_GREATER;
						fl_len   = ftl_pkg::LEN_W'(1);
						run_idle = 1'b1;
					end
				end
				default: run_idle = 1'b1;
			endcase
		end
	end

	assign ovf = ext && (pl_q >= MAX_LEN);

	// next state
	always_comb begin
		mode_d = mode_q;
		bp_d   = bp_q;
		ps_d   = ps_q;
		pl_d   = pl_q;
		err_d  = err_q;
		if (end_s1) begin
			mode_d = ftl_pkg::MODE_IDLE;
			bp_d   = '0;
			ps_d   = '0;
			pl_d   = '0;
			err_d  = 1'b0;
		end else begin
			if (bp_q != {ftl_pkg::POS_W{1'b1}}) begin
				bp_d = bp_q + ftl_pkg::POS_W'(1);
			end
			if (!err_q) begin
				if (ovf || fl_fail) begin
					err_d  = 1'b1;
					mode_d = ftl_pkg::MODE_IDLE;
					pl_d   = '0;
				end else if (ext) begin
					mode_d = ext_mode;
					pl_d   = pl_q + ftl_pkg::LEN_W'(1);
				end else if (done) begin
					mode_d = ftl_pkg::MODE_IDLE;
					pl_d   = '0;
				end else if (run_idle) begin
					mode_d = i_mode;
					if (i_begin) begin
						ps_d = bp_q;
						pl_d = ftl_pkg::LEN_W'(1);
					end else begin
						pl_d = '0;
					end
					if (i_fail) begin
						err_d = 1'b1;
					end
				end
			end
		end
	end

	// results
	always_comb begin
		n  = 2'd0;
		r0 = i_res;
		r1 = i_res;
		if (fl_v) begin
			r0 = '{kind: fl_kind, start: ps_q, len: fl_len, err: fl_err, last: 1'b0};
			n  = 2'd1;
			if (run_idle && i_emit) begin
				r1 = i_res;
				n  = 2'd2;
			end
		end else if (ovf) begin
			r0 = '{kind: ftl_pkg::KIND_EQUAL, start: ps_q, len: pl_q,
				err: ftl_pkg::ERR_TOO_LONG, last: 1'b0};
			n  = 2'd1;
		end else if (run_idle && i_emit) begin
			r0 = i_res;
			n  = 2'd1;
		end
		r0.last = (n == 2'd1);
		r1.last = (n == 2'd2);
	end

	assign push.cnt = step ? n : 2'd0;
	assign push.r0  = r0;
	assign push.r1  = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ftl_pkg::MODE_IDLE;
			bp_q   <= '0;
			ps_q   <= '0;
			pl_q   <= '0;
			err_q  <= 1'b0;
		end else if (step) begin
			mode_q <= mode_d;
			bp_q   <= bp_d;
			ps_q   <= ps_d;
			pl_q   <= pl_d;
			err_q  <= err_d;
		end
	end

endmodule

// ===== sv/formula_token_lexer_top.sv =====
`timescale 1ns / 1ps

// channel   dir  tdata                             tuser                  tlast
// s_axis    in   [7:0] char_byte                   -                      end_of_formula
// m_axis    out  [15:0] token_start,               [3:0] token_kind,      last_of_item
//                [21:16] token_length              [5:4] error_code
//
// one character per cycle while the result queue has room; a taken beat waits in the
// input register and moves on to the result queue when the queue has room
// a character gives up to two tokens, drained one per ready cycle from a 4-entry queue
// input stalls while a beat waits in the input register and the queue has
// fewer than two free entries
// arst_n clears mode, position, error latch and the queue

module formula_token_lexer_top #(
	parameter int MAX_TOKEN_LEN = ftl_pkg::MAX_TOKEN_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [15:0] token_start, [21:16] token_length
	output logic [5:0]  m_axis_tuser,   // [3:0] token_kind, [5:4] error_code
	output logic        m_axis_tlast
);

	ftl_pkg::push_t push;
	ftl_pkg::res_t  head;
	logic           room;

	ftl_lex_core #(
		.MAX_TOKEN_LEN(MAX_TOKEN_LEN)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_end   (s_axis_tlast),
		.room     (room),
		.push     (push)
	);

	ftl_out_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (m_axis_tready),
		.room       (room),
		.head_valid (m_axis_tvalid),
		.head       (head)
	);

	assign m_axis_tdata = {2'b00, head.len, head.start};
	assign m_axis_tuser = {head.err, head.kind};
	assign m_axis_tlast = head.last;

endmodule

// ===== sv/ftl_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ftl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [5:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	logic out_stall;
	logic err_beat;
	logic two_char;

	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign err_beat  = m_axis_tvalid && (m_axis_tuser[5:4] != ftl_pkg::ERR_NONE);
	assign two_char  = m_axis_tvalid && m_axis_tuser[5:4] == ftl_pkg::ERR_NONE &&
		(m_axis_tuser[3:0] == ftl_pkg::KIND_LESS_EQUAL ||
		m_axis_tuser[3:0] == ftl_pkg::KIND_GREATER_EQUAL ||
		m_axis_tuser[3:0] == ftl_pkg::KIND_NOT_EQUAL);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
	`ASSERT_IMPLY(a_err_kind, clk, arst_n, err_beat, m_axis_tuser[3:0] == ftl_pkg::KIND_EQUAL)
	`ASSERT_IMPLY(a_len_nonzero, clk, arst_n, m_axis_tvalid, m_axis_tdata[21:16] != 6'd0)
	`ASSERT_IMPLY(a_two_char_len, clk, arst_n, two_char, m_axis_tdata[21:16] == 6'd2)

endmodule

bind formula_token_lexer_top ftl_checker u_chk (.*);

// ===== sim/tb_formula_token_lexer_top.sv =====
`timescale 1ns / 1ps

module tb_formula_token_lexer_top;
	import ftl_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_ITEMS = 1700;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic [5:0]  m_axis_tuser;
	logic        m_axis_tlast;

	formula_token_lexer_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	class token_scoreboard;
		res_t             tokens_due[$];
		res_t             step_tokens[$];
		lex_mode_t        mode;
		logic [POS_W-1:0] next_pos;
		logic [POS_W-1:0] tok_start;
		logic [LEN_W-1:0] tok_len;
		bit               latched;
		int               mismatches;

		function new();
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			mode = MODE_IDLE;
			next_pos = '0;
			tok_start = '0;
			tok_len = '0;
			latched = 1'b0;
		endfunction

		function bit is_letter(logic [7:0] ch);
			return (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z");
		endfunction

		function bit is_digit(logic [7:0] ch);
			return ch >= "0" && ch <= "9";
		endfunction

		function bit is_blank(logic [7:0] ch);
			return ch == " " || (ch >= 8'h09 && ch <= 8'h0D);
		endfunction

		function void emit(tok_kind_t kind, logic [POS_W-1:0] start, logic [LEN_W-1:0] len,
				err_code_t err);
			res_t r;
			r.kind = kind;
			r.start = start;
			r.len = len;
			r.err = err;
			r.last = 1'b0;
			step_tokens.push_back(r);
		endfunction

		function void fail(logic [POS_W-1:0] start, logic [LEN_W-1:0] len, err_code_t err);
			latched = 1'b1;
			mode = MODE_IDLE;
			tok_len = '0;
			emit(KIND_EQUAL, start, len, err);
		endfunction

		function void grow(lex_mode_t m);
			if (tok_len >= MAX_TOKEN_LEN_DEF) begin
				fail(tok_start, tok_len, ERR_TOO_LONG);
			end else begin
				tok_len++;
				mode = m;
			end
		endfunction

		function void open_token(lex_mode_t m, logic [POS_W-1:0] at);
			mode = m;
			tok_start = at;
			tok_len = 1;
		endfunction

		function void from_idle(logic [7:0] ch, logic [POS_W-1:0] at);
			mode = MODE_IDLE;
			tok_len = '0;
			if (is_blank(ch)) return;
			if (is_letter(ch)) begin
				open_token(MODE_LETTERS, at);
			end else if (is_digit(ch)) begin
				open_token(MODE_NUMINT, at);
			end else if (ch == CH_LT) begin
				open_token(MODE_LT, at);
			end else if (ch == CH_GT) begin
				open_token(MODE_GT, at);
			end else begin
				case (ch)
					CH_EQUAL:  emit(KIND_EQUAL, at, 1, ERR_NONE);
					CH_PLUS:   emit(KIND_PLUS, at, 1, ERR_NONE);
					CH_MINUS:  emit(KIND_MINUS, at, 1, ERR_NONE);
					CH_STAR:   emit(KIND_MULTIPLY, at, 1, ERR_NONE);
					CH_SLASH:  emit(KIND_DIVIDE, at, 1, ERR_NONE);
					CH_LPAREN: emit(KIND_LPAREN, at, 1, ERR_NONE);
					CH_RPAREN: emit(KIND_RPAREN, at, 1, ERR_NONE);
					CH_COLON:  emit(KIND_COLON, at, 1, ERR_NONE);
					default:   fail(at, 1, ERR_UNEXPECTED);
				endcase
			end
		endfunction

		function void note_beat(logic [7:0] ch, logic eof);
			logic [POS_W-1:0] here;
			step_tokens.delete();
			if (eof) begin
				if (!latched) begin
					case (mode)
						MODE_LETTERS: emit(KIND_EQUAL, tok_start, tok_len, ERR_INVALID_IDENT);
						MODE_CELLDIG: emit(KIND_CELL, tok_start, tok_len, ERR_NONE);
						MODE_NUMINT, MODE_NUMFRAC: emit(KIND_NUMBER, tok_start, tok_len, ERR_NONE);
						MODE_LT: emit(KIND_LESS, tok_start, 1, ERR_NONE);
						MODE_GT: emit(KIND_GREATER, tok_start, 1, ERR_NONE);
						default: ;
					endcase
				end
				restart();
			end else begin
				here = next_pos;
				if (next_pos != '1) next_pos++;
				if (!latched) begin
					case (mode)
						MODE_LETTERS: begin
							if (is_letter(ch)) begin
								grow(MODE_LETTERS);
							end else if (is_digit(ch)) begin
								grow(MODE_CELLDIG);
							end else if (ch == CH_LPAREN) begin
								emit(KIND_FUNCTION, tok_start, tok_len, ERR_NONE);
								from_idle(ch, here);
							end else begin
								fail(tok_start, tok_len, ERR_INVALID_IDENT);
							end
						end
						MODE_CELLDIG: begin
							if (is_digit(ch)) begin
								grow(MODE_CELLDIG);
							end else begin
								emit(KIND_CELL, tok_start, tok_len, ERR_NONE);
								from_idle(ch, here);
							end
						end
						MODE_NUMINT, MODE_NUMFRAC: begin
							if (is_digit(ch)) begin
								grow(mode);
							end else if (ch == CH_DOT && mode == MODE_NUMINT) begin
								grow(MODE_NUMFRAC);
							end else begin
								emit(KIND_NUMBER, tok_start, tok_len, ERR_NONE);
								from_idle(ch, here);
							end
						end
						MODE_LT: begin
							if (ch == CH_EQUAL) begin
								emit(KIND_LESS_EQUAL, tok_start, 2, ERR_NONE);
								mode = MODE_IDLE;
								tok_len = '0;
							end else if (ch == CH_GT) begin
								emit(KIND_NOT_EQUAL, tok_start, 2, ERR_NONE);
								mode = MODE_IDLE;
								tok_len = '0;
							end else begin
								emit(KIND_LESS, tok_start, 1, ERR_NONE);
								from_idle(ch, here);
							end
						end
						MODE_GT: begin
							if (ch == CH_EQUAL) begin
								emit(KIND_GREATER_EQUAL, tok_start, 2, ERR_NONE);
								mode = MODE_IDLE;
								tok_len = '0;
							end else begin
								emit(KIND_GREATER, tok_start, 1, ERR_NONE);
								from_idle(ch, here);
							end
						end
						default: from_idle(ch, here);
					endcase
				end
			end
			if (step_tokens.size() != 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
			foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
		endfunction

		task report(string what, int got, int want);
			mismatches++;
			$display("%0t %s: got %0d, expected %0d", $time, what, got, want);
		endtask

		task check(res_t got);
			res_t want;
			if (tokens_due.size() == 0) begin
				report("token with none pending, kind", got.kind, -1);
				return;
			end
			want = tokens_due.pop_front();
			if (got.kind != want.kind) report("token_kind", got.kind, want.kind);
			if (got.start != want.start) report("token_start", got.start, want.start);
			if (got.len != want.len) report("token_length", got.len, want.len);
			if (got.err != want.err) report("error_code", got.err, want.err);
			if (got.last != want.last) report("last_of_item", got.last, want.last);
		endtask
	endclass

	token_scoreboard sb;
	int              idle_cycles = 0;
	int              items_sent;
	int              burst_left;
	bit              steady;
	bit              hold_req = 1'b0;
	logic [7:0]      text_q[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// monitor both channels at the rising edge
	always @(posedge clk) begin
		res_t got;
		if (s_axis_tvalid && s_axis_tready) sb.note_beat(s_axis_tdata, s_axis_tlast);
		if (m_axis_tvalid && m_axis_tready) begin
			got.kind = tok_kind_t'(m_axis_tuser[3:0]);
			got.err = err_code_t'(m_axis_tuser[5:4]);
			got.start = m_axis_tdata[15:0];
			got.len = m_axis_tdata[21:16];
			got.last = m_axis_tlast;
			sb.check(got);
		end
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	// receiver stall patterns, plus one long hold-off on request
	initial begin
		int style, span, phase;
		m_axis_tready = 1'b0;
		phase = 0;
		forever begin
			style = $urandom_range(0, 3);
			span = $urandom_range(16, 256);
			repeat (span) begin
				@(negedge clk);
				phase++;
				if (hold_req) begin
					hold_req = 1'b0;
					m_axis_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
				end
				case (style)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 3) != 0);
					2: m_axis_tready <= 1'($urandom_range(0, 1));
					default: m_axis_tready <= (phase % 7 < 3);
				endcase
			end
		end
	end

	function automatic logic [7:0] rand_letter();
		logic [7:0] ofs;
		ofs = 8'($urandom_range(0, 25));
		return ($urandom_range(0, 1) ? "a" : "A") + ofs;
	endfunction

	function automatic logic [7:0] rand_digit();
		logic [7:0] ofs;
		ofs = 8'($urandom_range(0, 9));
		return "0" + ofs;
	endfunction

	function automatic logic [7:0] rand_blank();
		logic [7:0] b;
		b = 8'($urandom_range(8'h09, 8'h0E));
		if (b == 8'h0E) b = " ";
		return b;
	endfunction

	function automatic void add_piece();
		int pick, n, lead;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			text_q.push_back(CH_EQUAL);
		end else if (pick < 25) begin
			n = $urandom_range(1, 3);
			repeat (n) text_q.push_back(rand_letter());
			n = $urandom_range(1, 4);
			repeat (n) text_q.push_back(rand_digit());
		end else if (pick < 35) begin
			n = $urandom_range(1, 6);
			repeat (n) text_q.push_back(rand_letter());
			text_q.push_back(CH_LPAREN);
		end else if (pick < 50) begin
			n = $urandom_range(1, 5);
			repeat (n) text_q.push_back(rand_digit());
			if ($urandom_range(0, 4) < 2) begin
				text_q.push_back(CH_DOT);
				n = $urandom_range(0, 4);
				repeat (n) text_q.push_back(rand_digit());
			end
		end else if (pick < 70) begin
			case ($urandom_range(0, 6))
				0: text_q.push_back(CH_PLUS);
				1: text_q.push_back(CH_MINUS);
				2: text_q.push_back(CH_STAR);
				3: text_q.push_back(CH_SLASH);
				4: text_q.push_back(CH_LPAREN);
				5: text_q.push_back(CH_RPAREN);
				default: text_q.push_back(CH_COLON);
			endcase
		end else if (pick < 80) begin
			case ($urandom_range(0, 4))
				0: text_q.push_back(CH_LT);
				1: begin text_q.push_back(CH_LT); text_q.push_back(CH_EQUAL); end
				2: text_q.push_back(CH_GT);
				3: begin text_q.push_back(CH_GT); text_q.push_back(CH_EQUAL); end
				default: begin text_q.push_back(CH_LT); text_q.push_back(CH_GT); end
			endcase
		end else if (pick < 88) begin
			n = $urandom_range(1, 4);
			repeat (n) text_q.push_back(rand_letter());
		end else if (pick < 94) begin
			text_q.push_back(8'($urandom_range(0, 255)));
		end else if (pick < 95) begin
			// runs around the length limit
			n = $urandom_range(47, 52);
			if ($urandom_range(0, 1)) begin
				lead = $urandom_range(1, 3);
				repeat (lead) text_q.push_back(rand_letter());
				repeat (n - lead) text_q.push_back(rand_digit());
			end else begin
				repeat (n) text_q.push_back(rand_digit());
			end
		end else begin
			n = $urandom_range(1, 3);
			repeat (n) text_q.push_back(rand_blank());
		end
		if ($urandom_range(0, 1)) text_q.push_back(rand_blank());
	endfunction

	task automatic send_beat(input logic [7:0] ch, input logic eof);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = steady ? 0 : $urandom_range(0, 8);
			if (gap != 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ch;
		s_axis_tlast <= eof;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		items_sent++;
	endtask

	task automatic send_formula();
		foreach (text_q[i]) send_beat(text_q[i], 1'b0);
		send_beat(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic send_text(input string s);
		text_q.delete();
		for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
		send_formula();
	endtask

	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.tokens_due.size() != 0) @(posedge clk);
		burst_left = 0;
	endtask

	initial begin
		int n;
		bit pressed;
		sb = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		items_sent = 0;
		burst_left = 0;
		steady = 1'b0;
		pressed = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_text("=a1+F(2.5)");
		send_text("<=>=<><-*>/:x");
		send_text("ab$");
		send_text("7#");
		send_text("");
		settle();

		while (items_sent < RANDOM_ITEMS) begin
			steady = ($urandom_range(0, 3) == 0);
			if (!pressed && items_sent > RANDOM_ITEMS / 2) begin
				// receiver holds off while the sender keeps offering
				pressed = 1'b1;
				steady = 1'b1;
				hold_req = 1'b1;
				text_q.delete();
				repeat (40) text_q.push_back(CH_PLUS);
				send_formula();
			end
			text_q.delete();
			if ($urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 8);
				repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				n = $urandom_range(1, 10);
				repeat (n) add_piece();
			end
			send_formula();
			if ($urandom_range(0, 11) == 0) settle();
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.tokens_due.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.mismatches == 0 && sb.tokens_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
